[sv/mss_pkg.sv]
package mss_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned REG_SEPS = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LEN_FIELD_W = 3;
  localparam int unsigned LENGTHS_W = 12;

  localparam logic [KIND_W-1:0] KIND_UNIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT_END = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEP_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS = 3'd4;

  localparam logic [UNIT_W-1:0] DEFAULT_SEP = 16'd59;

  // Selects which result the datapath presents on its outputs.
  localparam logic [1:0] SEL_PENDING = 2'd0;
  localparam logic [1:0] SEL_SPACE = 2'd1;
  localparam logic [1:0] SEL_VEND = 2'd2;
  localparam logic [1:0] SEL_TEND = 2'd3;

  function automatic logic is_space(input logic [UNIT_W-1:0] u);
    return (u >= 16'd9 && u <= 16'd13) || u == 16'd32 || u == 16'h85 || u == 16'hA0;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Latch the accepted transaction into the window.
    logic pop;        // Decide the window head.
    logic flush;      // Emit the next held space.
    logic emit_unit;  // Emit the pending non-space unit.
    logic emit_vend;  // Emit end of value.
    logic emit_tend;  // Emit end of text.
    logic finish;     // Clear per-text state.
    logic [1:0] res_sel;
  } mss_cmd_t;

  typedef struct packed {
    logic fill_full;    // Window holds the maximum number of units.
    logic fill_zero;
    logic head_sep;     // Head starts a separator and is not skipped.
    logic head_take;    // Head is a non-space unit to send.
    logic head_skip;
    logic value_open;
    logic held_more;    // Held spaces remain to flush.
    logic last;         // Latched text end flag.
  } mss_stat_t;

endpackage

[sv/mss_datapath.sv]
module mss_datapath #(
  parameter int unsigned SEPARATOR_COUNT = 4,
  parameter int unsigned MAX_SEPARATOR_UNITS = 4,
  parameter int unsigned SPACE_HOLD_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [mss_pkg::UNIT_W-1:0] code_unit,
  input  logic text_end,
  input  mss_pkg::mss_cmd_t cmd,
  output mss_pkg::mss_stat_t stat,
  output logic [mss_pkg::UNIT_W-1:0] res_unit,
  output logic [mss_pkg::KIND_W-1:0] res_kind,
  output logic res_ovf
);

  localparam int unsigned MSU = MAX_SEPARATOR_UNITS;
  localparam int unsigned FILL_W = $clog2(MSU + 1);
  localparam int unsigned WIN_IDX_W = (MSU > 1) ? $clog2(MSU) : 1;
  localparam int unsigned HOLD_IDX_W = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;
  localparam int unsigned HOLD_CNT_W = $clog2(SPACE_HOLD_DEPTH + 1);
  localparam int unsigned NSEP = (SEPARATOR_COUNT < mss_pkg::REG_SEPS) ?
                                 SEPARATOR_COUNT : mss_pkg::REG_SEPS;

  logic [63:0] sep_regs [mss_pkg::REG_SEPS];
  logic [mss_pkg::LENGTHS_W-1:0] sep_lengths;

  logic [mss_pkg::UNIT_W-1:0] window [MSU];
  logic [FILL_W-1:0] fill;
  logic [1:0] skip;
  logic [mss_pkg::UNIT_W-1:0] held [SPACE_HOLD_DEPTH];
  logic [HOLD_CNT_W-1:0] held_count;
  logic [HOLD_CNT_W-1:0] flush_idx;
  logic value_open;
  logic overflow_seen;
  logic last;
  logic [mss_pkg::UNIT_W-1:0] pending;

  logic [2:0] best;
  logic any_sep;
  logic [2:0] lens [NSEP];
  logic [2:0] raw_len;
  logic match_ok;
  logic [mss_pkg::UNIT_W-1:0] head;

  always_comb begin
    best = '0;
    any_sep = 1'b0;
    raw_len = '0;
    match_ok = 1'b0;
    for (int i = 0; i < NSEP; i++) begin
      raw_len = sep_lengths[i*mss_pkg::LEN_FIELD_W +: mss_pkg::LEN_FIELD_W];
      lens[i] = (raw_len > 3'(MSU)) ? 3'(MSU) : raw_len;
    end
    for (int i = 0; i < NSEP; i++) begin
      if (lens[i] != 3'd0) begin
        any_sep = 1'b1;
        match_ok = ({1'b0, lens[i]} <= 4'(fill)) && (lens[i] > best);
        for (int j = 0; j < MSU; j++) begin
          if (3'(j) < lens[i] && window[j] != sep_regs[i][16*j +: 16]) match_ok = 1'b0;
        end
        if (match_ok) best = lens[i];
      end
    end
    if (!any_sep && fill != '0 && window[0] == mss_pkg::DEFAULT_SEP) best = 3'd1;
  end

  assign head = window[0];
  assign stat.fill_full = (fill == FILL_W'(MSU));
  assign stat.fill_zero = (fill == '0);
  assign stat.head_skip = (skip != 2'd0);
  assign stat.head_sep = (skip == 2'd0) && (best != 3'd0);
  assign stat.head_take = (skip == 2'd0) && (best == 3'd0) && !mss_pkg::is_space(head);
  assign stat.value_open = value_open;
  assign stat.held_more = (flush_idx < held_count);
  assign stat.last = last;

  always_comb begin
    res_unit = '0;
    res_kind = mss_pkg::KIND_UNIT;
    res_ovf = 1'b0;
    unique case (cmd.res_sel)
      mss_pkg::SEL_SPACE: begin
        res_unit = held[flush_idx[HOLD_IDX_W-1:0]];
        res_ovf = overflow_seen;
      end
      mss_pkg::SEL_PENDING: begin
        res_unit = pending;
        res_ovf = overflow_seen;
      end
      mss_pkg::SEL_VEND: res_kind = mss_pkg::KIND_VALUE_END;
      mss_pkg::SEL_TEND: res_kind = mss_pkg::KIND_TEXT_END;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_regs[0] <= 64'd59;
      sep_regs[1] <= '0;
      sep_regs[2] <= '0;
      sep_regs[3] <= '0;
      sep_lengths <= 12'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mss_pkg::CFG_SEP_A: sep_regs[0] <= cfg_data;
        mss_pkg::CFG_SEP_B: sep_regs[1] <= cfg_data;
        mss_pkg::CFG_SEP_C: sep_regs[2] <= cfg_data;
        mss_pkg::CFG_SEP_D: sep_regs[3] <= cfg_data;
        mss_pkg::CFG_LENGTHS: sep_lengths <= cfg_data[mss_pkg::LENGTHS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop && skip == 2'd0 && best == 3'd0 && mss_pkg::is_space(head) && value_open &&
        held_count < HOLD_CNT_W'(SPACE_HOLD_DEPTH)) begin
      held[held_count[HOLD_IDX_W-1:0]] <= head;
    end
    if (cmd.pop) pending <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MSU; i++) window[i] <= '0;
      fill <= '0;
      skip <= '0;
      held_count <= '0;
      flush_idx <= '0;
      value_open <= 1'b0;
      overflow_seen <= 1'b0;
      last <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (fill < FILL_W'(MSU)) begin
          window[fill[WIN_IDX_W-1:0]] <= code_unit;
          fill <= fill + 1'b1;
        end
        last <= text_end;
      end
      if (cmd.pop) begin
        for (int i = 1; i < MSU; i++) window[i-1] <= window[i];
        window[MSU-1] <= '0;
        fill <= fill - 1'b1;
        if (skip != 2'd0) begin
          skip <= skip - 2'd1;
        end else if (best != 3'd0) begin
          skip <= 2'(best - 3'd1);
        end else if (mss_pkg::is_space(head)) begin
          if (value_open) begin
            if (held_count < HOLD_CNT_W'(SPACE_HOLD_DEPTH)) held_count <= held_count + 1'b1;
            else overflow_seen <= 1'b1;
          end
        end
        flush_idx <= '0;
      end
      if (cmd.flush) flush_idx <= flush_idx + 1'b1;
      if (cmd.emit_unit) begin
        held_count <= '0;
        flush_idx <= '0;
        overflow_seen <= 1'b0;
        value_open <= 1'b1;
      end
      if (cmd.emit_vend) begin
        held_count <= '0;
        overflow_seen <= 1'b0;
        value_open <= 1'b0;
      end
      if (cmd.finish) begin
        for (int i = 0; i < MSU; i++) window[i] <= '0;
        fill <= '0;
        skip <= '0;
        held_count <= '0;
        flush_idx <= '0;
        value_open <= 1'b0;
        overflow_seen <= 1'b0;
        last <= 1'b0;
      end
    end
  end

endmodule

[sv/mss_ctrl.sv]
module mss_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic res_last,
  input  mss_pkg::mss_stat_t stat,
  output mss_pkg::mss_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_UNIT = 3'd3;
  localparam logic [2:0] S_VEND = 3'd4;
  localparam logic [2:0] S_TEND = 3'd5;
  localparam logic [2:0] S_CLOSE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic more_pops;

  // After a head is handled, more heads remain only while draining at text end.
  assign more_pops = stat.last && !stat.fill_zero;

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    res_last = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.last ? stat.fill_zero : !stat.fill_full) begin
          state_next = stat.last ? S_CLOSE : S_IDLE;
        end else begin
          cmd.pop = 1'b1;
          if (stat.head_skip) state_next = S_DECIDE;
          else if (stat.head_sep) state_next = stat.value_open ? S_VEND : S_DECIDE;
          else if (stat.head_take) state_next = S_FLUSH;
          else state_next = S_DECIDE;
          if (!stat.last && !(stat.head_sep && stat.value_open) && !stat.head_take &&
              !stat.head_skip) state_next = S_IDLE;
          if (!stat.last && stat.head_skip) state_next = S_IDLE;
          if (!stat.last && stat.head_sep && !stat.value_open) state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.held_more) begin
          out_valid = 1'b1;
          cmd.res_sel = mss_pkg::SEL_SPACE;
          cmd.flush = out_ready;
        end else begin
          state_next = S_UNIT;
        end
      end
      S_UNIT: begin
        out_valid = 1'b1;
        cmd.res_sel = mss_pkg::SEL_PENDING;
        res_last = !more_pops && !stat.last;
        if (out_ready) begin
          cmd.emit_unit = 1'b1;
          state_next = stat.last ? S_DECIDE : S_IDLE;
        end
      end
      S_VEND: begin
        out_valid = 1'b1;
        cmd.res_sel = mss_pkg::SEL_VEND;
        res_last = !stat.last;
        if (out_ready) begin
          cmd.emit_vend = 1'b1;
          state_next = stat.last ? S_DECIDE : S_IDLE;
        end
      end
      S_CLOSE: begin
        if (stat.value_open) begin
          out_valid = 1'b1;
          cmd.res_sel = mss_pkg::SEL_VEND;
          if (out_ready) cmd.emit_vend = 1'b1;
        end else begin
          state_next = S_TEND;
        end
      end
      S_TEND: begin
        out_valid = 1'b1;
        cmd.res_sel = mss_pkg::SEL_TEND;
        res_last = 1'b1;
        if (out_ready) begin
          cmd.emit_tend = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

[sv/multi_separator_text_splitter.sv]
// Splits UTF-16 text into trimmed values at up to four configured separators,
// longest match first, seen through a lookahead window of MAX_SEPARATOR_UNITS
// code units. One transaction per code unit; results are
// value units, value ends and a final end of text, with run_last on the last
// result of each input transaction. A transaction is loaded in idle; once the
// window is full the head is decided, held spaces are flushed and a released
// non-space unit is sent. A transaction with text_end also drains the rest of the
// window and closes the text. Each result waits while out_ready is low.
// The controller decides one window head at a time.
module multi_separator_text_splitter #(
  parameter int unsigned SEPARATOR_COUNT = 4,
  parameter int unsigned MAX_SEPARATOR_UNITS = 4,
  parameter int unsigned SPACE_HOLD_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [mss_pkg::UNIT_W-1:0] code_unit,
  input  logic text_end,
  output logic out_valid,
  input  logic out_ready,
  output logic [mss_pkg::UNIT_W-1:0] out_unit,
  output logic [mss_pkg::KIND_W-1:0] kind,
  output logic space_overflow,
  output logic run_last
);

  mss_pkg::mss_cmd_t cmd;
  mss_pkg::mss_stat_t stat;

  assign cfg_ready = 1'b1;

  mss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .res_last(run_last),
    .stat(stat), .cmd(cmd)
  );

  mss_datapath #(
    .SEPARATOR_COUNT(SEPARATOR_COUNT),
    .MAX_SEPARATOR_UNITS(MAX_SEPARATOR_UNITS),
    .SPACE_HOLD_DEPTH(SPACE_HOLD_DEPTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .code_unit(code_unit), .text_end(text_end),
    .cmd(cmd), .stat(stat), .res_unit(out_unit), .res_kind(kind),
    .res_ovf(space_overflow)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam logic [mss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned WIN = 4;
  localparam int unsigned HOLD = 16;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [mss_pkg::UNIT_W-1:0] unit;
    logic [mss_pkg::KIND_W-1:0] kind;
    logic ovf;
    logic last;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [mss_pkg::UNIT_W-1:0] code_unit = '0;
  logic text_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [mss_pkg::UNIT_W-1:0] out_unit;
  logic [mss_pkg::KIND_W-1:0] kind;
  logic space_overflow;
  logic run_last;

  multi_separator_text_splitter i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .code_unit(code_unit), .text_end(text_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_unit(out_unit), .kind(kind),
    .space_overflow(space_overflow), .run_last(run_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic [63:0] sep_chars [mss_pkg::REG_SEPS];
  logic [mss_pkg::LENGTHS_W-1:0] sep_lens;
  logic [mss_pkg::UNIT_W-1:0] window [WIN];
  int unsigned fill, skip_left, held_n;
  logic [mss_pkg::UNIT_W-1:0] held [HOLD];
  bit value_open, overflow_seen;

  token_t expected_tokens[$];
  bit failed = 1'b0;
  bit idle_on = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned cycles = 0;

  function automatic bit is_ws(logic [mss_pkg::UNIT_W-1:0] u);
    return (u >= 16'd9 && u <= 16'd13) || u == 16'd32 || u == 16'h85 || u == 16'hA0;
  endfunction

  function automatic int unsigned sep_len_of(int unsigned i);
    int unsigned raw;
    raw = sep_lens[mss_pkg::LEN_FIELD_W*i +: mss_pkg::LEN_FIELD_W];
    return raw > WIN ? WIN : raw;
  endfunction

  function automatic int unsigned longest_match();
    int unsigned best, len;
    bit any, ok;
    best = 0;
    any = 0;
    for (int unsigned i = 0; i < mss_pkg::REG_SEPS; i++) begin
      len = sep_len_of(i);
      if (len != 0) begin
        any = 1;
        if (len <= fill && len > best) begin
          ok = 1;
          for (int unsigned j = 0; j < len; j++)
            if (window[j] != sep_chars[i][mss_pkg::UNIT_W*j +: mss_pkg::UNIT_W]) ok = 0;
          if (ok) best = len;
        end
      end
    end
    if (!any && fill >= 1 && window[0] == mss_pkg::DEFAULT_SEP) best = 1;
    return best;
  endfunction

  function automatic void push_token(logic [mss_pkg::UNIT_W-1:0] u,
                                     logic [mss_pkg::KIND_W-1:0] k, bit o);
    token_t t;
    t.unit = u;
    t.kind = k;
    t.ovf = o;
    t.last = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void close_value();
    if (value_open) push_token('0, mss_pkg::KIND_VALUE_END, 1'b0);
    value_open = 0;
    held_n = 0;
    overflow_seen = 0;
  endfunction

  function automatic void take_unit(logic [mss_pkg::UNIT_W-1:0] u);
    if (is_ws(u)) begin
      if (!value_open) return;
      if (held_n < HOLD) begin
        held[held_n] = u;
        held_n++;
      end else begin
        overflow_seen = 1;
      end
      return;
    end
    for (int unsigned i = 0; i < held_n; i++)
      push_token(held[i], mss_pkg::KIND_UNIT, overflow_seen);
    push_token(u, mss_pkg::KIND_UNIT, overflow_seen);
    held_n = 0;
    overflow_seen = 0;
    value_open = 1;
  endfunction

  function automatic void decide_head();
    int unsigned k;
    logic [mss_pkg::UNIT_W-1:0] u;
    if (fill == 0) return;
    k = longest_match();
    u = window[0];
    for (int unsigned i = 1; i < WIN; i++) window[i-1] = window[i];
    window[WIN-1] = '0;
    fill--;
    if (skip_left > 0) begin
      skip_left--;
    end else if (k > 0) begin
      close_value();
      skip_left = k - 1;
    end else begin
      take_unit(u);
    end
  endfunction

  function automatic void split_step(logic [mss_pkg::UNIT_W-1:0] u, bit last);
    int unsigned n0;
    n0 = expected_tokens.size();
    if (fill < WIN) begin
      window[fill] = u;
      fill++;
    end
    if (!last) begin
      if (fill >= WIN) decide_head();
    end else begin
      while (fill > 0) decide_head();
      close_value();
      push_token('0, mss_pkg::KIND_TEXT_END, 1'b0);
      skip_left = 0;
      for (int unsigned i = 0; i < WIN; i++) window[i] = '0;
    end
    if (expected_tokens.size() > n0) expected_tokens[expected_tokens.size()-1].last = 1'b1;
  endfunction

  // Receiver: random stalls plus an optional long hold-off.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall = $urandom_range(1, 14) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    token_t t;
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected result unit=%h kind=%0d", out_unit, kind);
        failed = 1'b1;
      end else begin
        t = expected_tokens.pop_front();
        if (out_unit !== t.unit) begin
          $error("out_unit expected %h actual %h", t.unit, out_unit);
          failed = 1'b1;
        end
        if (kind !== t.kind) begin
          $error("kind expected %0d actual %0d", t.kind, kind);
          failed = 1'b1;
        end
        if (space_overflow !== t.ovf) begin
          $error("space_overflow expected %0d actual %0d", t.ovf, space_overflow);
          failed = 1'b1;
        end
        if (run_last !== t.last) begin
          $error("run_last expected %0d actual %0d", t.last, run_last);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_unit(logic [mss_pkg::UNIT_W-1:0] u, bit last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    code_unit = u;
    text_end = last;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    split_step(u, last);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [mss_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    wait_drained();
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < mss_pkg::REG_SEPS) sep_chars[idx] = data;
    else if (idx == mss_pkg::CFG_LENGTHS) sep_lens = data[mss_pkg::LENGTHS_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_string(string s, bit finish_text);
    for (int i = 0; i < s.len(); i++)
      send_unit(mss_pkg::UNIT_W'(s[i]), finish_text && i == s.len() - 1);
  endtask

  function automatic logic [63:0] pack4(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 4; i++)
      v[mss_pkg::UNIT_W*i +: mss_pkg::UNIT_W] = mss_pkg::UNIT_W'(s[i]);
    return v;
  endfunction

  function automatic logic [mss_pkg::UNIT_W-1:0] random_unit();
    int unsigned r, i;
    logic [mss_pkg::UNIT_W-1:0] spaces [8];
    spaces = '{16'd9, 16'd10, 16'd11, 16'd12, 16'd13, 16'd32, 16'h85, 16'hA0};
    r = $urandom_range(0, 99);
    i = $urandom_range(0, mss_pkg::REG_SEPS - 1);
    if (r < 35) return mss_pkg::UNIT_W'($urandom_range(97, 100));
    if (r < 55) return spaces[$urandom_range(0, 7)];
    if (r < 80) return sep_chars[i][mss_pkg::UNIT_W*$urandom_range(0, 3) +: mss_pkg::UNIT_W];
    if (r < 85) return mss_pkg::DEFAULT_SEP;
    return mss_pkg::UNIT_W'($urandom());
  endfunction

  task automatic send_random_text(int unsigned maxlen);
    int unsigned len, i;
    len = $urandom_range(1, maxlen);
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        i = $urandom_range(0, mss_pkg::REG_SEPS - 1);
        for (int unsigned j = 0; j < sep_len_of(i) && n < len; j++, n++)
          send_unit(sep_chars[i][mss_pkg::UNIT_W*j +: mss_pkg::UNIT_W], n == len - 1);
        n--;
      end else begin
        send_unit(random_unit(), n == len - 1);
      end
    end
  endtask

  task automatic random_config();
    logic [63:0] v;
    for (int r = 0; r < mss_pkg::REG_SEPS; r++) begin
      v = '0;
      for (int j = 0; j < 4; j++)
        v[mss_pkg::UNIT_W*j +: mss_pkg::UNIT_W] =
            ($urandom_range(0, 9) == 0) ? mss_pkg::UNIT_W'($urandom())
                                        : mss_pkg::UNIT_W'($urandom_range(97, 100));
      write_reg(mss_pkg::CFG_IDX_W'(r), v);
    end
    write_reg(mss_pkg::CFG_LENGTHS, mss_pkg::LENGTHS_W'($urandom()));
  endtask

  task automatic test_default_separator();
    send_string("  ab ; c\td  ;;  ;x", 1'b1);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h85, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'hA0, 1'b0);
    send_unit(mss_pkg::DEFAULT_SEP, 1'b1);
    send_unit(16'd32, 1'b1);
  endtask

  task automatic test_longest_match();
    write_reg(mss_pkg::CFG_SEP_A, pack4("-->"));
    write_reg(mss_pkg::CFG_SEP_B, pack4("-"));
    write_reg(mss_pkg::CFG_SEP_C, pack4("->"));
    write_reg(mss_pkg::CFG_SEP_D, pack4("abcd"));
    write_reg(mss_pkg::CFG_LENGTHS, {3'd4, 3'd2, 3'd1, 3'd3});
    send_string("x-->y->z-w abcdq-->", 1'b1);
    send_string("p-", 1'b1);
    send_string("ab->", 1'b1);
    write_reg(mss_pkg::CFG_LENGTHS, {3'd7, 3'd5, 3'd6, 3'd7});
    send_string("uabcdv-->w", 1'b1);
  endtask

  task automatic test_no_separator();
    write_reg(mss_pkg::CFG_LENGTHS, '0);
    send_string("a;b--> c ;", 1'b1);
    write_reg(CFG_UNUSED, '1);
    send_string("e;f", 1'b1);
  endtask

  task automatic test_space_overflow();
    send_unit(mss_pkg::UNIT_W'("x"), 1'b0);
    for (int i = 0; i < 20; i++) send_unit(16'd32, 1'b0);
    send_unit(mss_pkg::UNIT_W'("y"), 1'b0);
    for (int i = 0; i < 20; i++) send_unit(16'd9, 1'b0);
    send_string(";z", 1'b1);
  endtask

  task automatic test_random_texts(int unsigned texts);
    for (int unsigned t = 0; t < texts; t++) begin
      if (t % 8 == 0) random_config();
      send_random_text(24);
    end
  endtask

  task automatic test_backpressure();
    write_reg(mss_pkg::CFG_LENGTHS, {3'd0, 3'd0, 3'd0, 3'd1});
    write_reg(mss_pkg::CFG_SEP_A, {48'd0, mss_pkg::DEFAULT_SEP});
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) send_unit(mss_pkg::UNIT_W'($urandom_range(97, 100)), 1'b0);
    wait_drained();
    for (int i = 0; i < 10; i++) send_unit(random_unit(), 1'b0);
    wait_drained();
    send_string(";q ", 1'b1);
  endtask

  task automatic test_extreme_config();
    write_reg(mss_pkg::CFG_SEP_A, '1);
    write_reg(mss_pkg::CFG_SEP_B, '0);
    write_reg(mss_pkg::CFG_SEP_C, '1);
    write_reg(mss_pkg::CFG_SEP_D, '0);
    write_reg(mss_pkg::CFG_LENGTHS, '1);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0041, 1'b0);
    for (int i = 0; i < 4; i++) send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0000, 1'b1);
  endtask

  initial begin
    sep_chars[0] = 64'd59;
    for (int i = 1; i < mss_pkg::REG_SEPS; i++) sep_chars[i] = '0;
    sep_lens = 12'd1;
    for (int i = 0; i < WIN; i++) window[i] = '0;
    fill = 0;
    skip_left = 0;
    held_n = 0;
    value_open = 0;
    overflow_seen = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_separator();
    test_space_overflow();
    test_longest_match();
    test_no_separator();
    test_extreme_config();
    test_backpressure();
    test_random_texts(16);
    idle_on = 1'b0;
    test_random_texts(8);

    wait_drained();
    repeat (40) @(posedge clk);
    if (!failed && expected_tokens.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/mss_pkg.sv
sv/mss_datapath.sv
sv/mss_ctrl.sv
sv/multi_separator_text_splitter.sv
tb/tb_top.sv
